@@ hdl/command_line_tokenizer_macros.svh @@
// Assertion macros used by the command line tokenizer RTL.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset.
`define CLT_ASSERT_ALWAYS(label, clock, reset_n, cond) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond)) \
        else $error("command_line_tokenizer: invariant violated");

// Check that a trigger is followed by a consequence in the next cycle.
`define CLT_ASSERT_NEXT(label, clock, reset_n, trig, cons) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (trig) |=> (cons)) \
        else $error("command_line_tokenizer: sequence violated");

`else

`define CLT_ASSERT_ALWAYS(label, clock, reset_n, cond)
`define CLT_ASSERT_NEXT(label, clock, reset_n, trig, cons)

`endif

`endif

@@ hdl/clt_pkg.sv @@
// Shared types, byte codes and classifiers for the command line tokenizer.
package clt_pkg;

    localparam int COUNT_LIMIT = 255;
    localparam int TOTAL_W     = $clog2(COUNT_LIMIT + 1);
    localparam int COUNT_W     = 8;
    localparam int WIDE_W      = (TOTAL_W > COUNT_W) ? TOTAL_W : COUNT_W;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Line state carried from one byte to the next.
    typedef struct packed {
        logic               in_quotes;
        logic               prev_bslash;
        logic               token_open;
        logic [TOTAL_W-1:0] token_total;
        logic               line_stopped;
    } line_state_t;

    // Result word for one byte.
    typedef struct packed {
        logic [7:0]         char_out;
        logic               char_valid;
        logic               token_end;
        logic               token_is_command;
        logic               token_discard;
        logic               line_done;
        logic               line_valid;
        logic [COUNT_W-1:0] value_count;
    } token_word_t;

    function automatic logic is_split(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_COLON) ||
               (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_LBRACE) ||
               (c == CH_RBRACE) || (c == CH_LBRK) || (c == CH_RBRK);
    endfunction

    function automatic logic is_end(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF) || (c == CH_SEMI) || (c == CH_NUL);
    endfunction

endpackage

@@ hdl/clt_line_if.sv @@
// Input channel: one raw byte of the command line per word.
interface clt_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_in;

    modport source (output valid, output char_in, output last_in, input ready);
    modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

@@ hdl/clt_token_if.sv @@
// Output channel: one result word per input byte.
interface clt_token_if;
    import clt_pkg::*;

    logic               valid;
    logic               ready;
    logic [7:0]         char_out;
    logic               char_valid;
    logic               token_end;
    logic               token_is_command;
    logic               token_discard;
    logic               line_done;
    logic               line_valid;
    logic [COUNT_W-1:0] value_count;

    modport source (output valid, output char_out, output char_valid, output token_end,
                    output token_is_command, output token_discard, output line_done,
                    output line_valid, output value_count, input ready);
    modport sink   (input valid, input char_out, input char_valid, input token_end,
                    input token_is_command, input token_discard, input line_done,
                    input line_valid, input value_count, output ready);
endinterface

@@ hdl/clt_step.sv @@
// Per-byte tokenizer logic: next line state and the result word for one byte.
module clt_step (
    input  clt_pkg::line_state_t cur,
    input  logic [7:0]           char_in,
    input  logic                 last_in,
    output clt_pkg::line_state_t nxt,
    output clt_pkg::token_word_t word
);
    import clt_pkg::*;

    logic               quote;
    logic               q_next;
    logic               split;
    logic               ends;
    logic               printable;
    logic               is_eq;
    logic               breaks;
    logic               close_tok;
    line_state_t        st;
    logic [WIDE_W-1:0]  vc_wide;

    always_comb
    begin
        split     = is_split(char_in);
        ends      = is_end(char_in);
        quote     = (char_in == CH_DQUOTE) && !cur.prev_bslash;
        q_next    = cur.in_quotes ^ quote;
        printable = !char_in[7] && (char_in >= CH_SPACE);
        is_eq     = (char_in == CH_EQUAL);
        breaks    = !q_next && (split || ends || last_in ||
                    (cur.token_total == '0 && is_eq) ||
                    (cur.token_total == TOTAL_W'(1) && !cur.token_open && is_eq));

        st        = cur;
        word      = '0;
        close_tok = 1'b0;
        vc_wide   = '0;

        if (!cur.line_stopped)
        begin
            if (!cur.in_quotes && char_in == CH_HASH)
            begin
                // comment: close any open token, ignore the rest of the line
                close_tok       = cur.token_open;
                st.line_stopped = 1'b1;
            end
            else
            begin
                st.in_quotes   = q_next;
                st.prev_bslash = (char_in == CH_BSLASH);
                if (breaks)
                begin
                    if (last_in && !ends && !split && !quote && printable)
                    begin
                        word.char_out   = char_in;
                        word.char_valid = 1'b1;
                        st.token_open   = 1'b1;
                    end
                    close_tok = st.token_open;
                    if (ends)
                    begin
                        st.line_stopped = 1'b1;
                    end
                end
                else if (printable && !(cur.token_total == '0 && is_eq) && !quote &&
                         !(char_in == CH_BSLASH && !q_next))
                begin
                    word.char_out   = char_in;
                    word.char_valid = 1'b1;
                    st.token_open   = 1'b1;
                end
            end

            if (close_tok)
            begin
                word.token_end        = 1'b1;
                word.token_is_command = (cur.token_total == '0);
                if (cur.token_total < TOTAL_W'(COUNT_LIMIT))
                begin
                    st.token_total = cur.token_total + TOTAL_W'(1);
                end
                st.token_open = 1'b0;
            end
        end

        nxt = st;
        if (last_in)
        begin
            word.line_done     = 1'b1;
            word.token_discard = st.token_open;
            word.line_valid    = (st.token_total != '0);
            if (st.token_total != '0)
            begin
                vc_wide = WIDE_W'(st.token_total) - WIDE_W'(1);
                if (vc_wide > WIDE_W'(255))
                begin
                    word.value_count = '1;
                end
                else
                begin
                    word.value_count = vc_wide[COUNT_W-1:0];
                end
            end
            nxt = '0;
        end
    end

endmodule

@@ hdl/command_line_tokenizer.sv @@
// Command line tokenizer: splits a byte stream into tokens with a line summary.
//
// Takes one command line byte per word on char_stream and gives exactly one result
// word per byte on token_stream. Throughput is one byte per cycle while token_stream
// is ready. The byte is held in an input register when it is accepted, the per-byte
// decode lands in the result register, and the result word is then offered on
// token_stream. The loop that sets the rate is the line state update (quote flag,
// open token, token count, stop flag), which closes in the decode between the two
// registers. Tokens split on space , : ( ) { } [ ]; CR, LF, ';' and NUL end the
// line; an unquoted '#' starts a comment. All line state returns to its reset value
// after the word for the byte flagged last. No clearing pass is needed after reset.
`include "command_line_tokenizer_macros.svh"

module command_line_tokenizer (
    input  logic  clk,
    input  logic  rst_n,
    clt_line_if.sink    char_stream,
    clt_token_if.source token_stream
);
    import clt_pkg::*;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_last_reg;

    // line state and result register
    line_state_t state_reg;
    line_state_t state_next;
    logic        out_valid_reg;
    token_word_t out_word_reg;
    token_word_t out_word_next;

    logic        advance;

    // Advance the input word into the result register when that slot is free or
    // its word is being taken this cycle.
    assign advance           = in_valid_reg && (!out_valid_reg || token_stream.ready);
    assign char_stream.ready = !in_valid_reg || advance;

    clt_step u_step (
        .cur     (state_reg),
        .char_in (in_char_reg),
        .last_in (in_last_reg),
        .nxt     (state_next),
        .word    (out_word_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (char_stream.ready)
            begin
                in_valid_reg <= char_stream.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (token_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: hold while stalled, no reset.
    always_ff @(posedge clk)
    begin
        if (char_stream.ready && char_stream.valid)
        begin
            in_char_reg <= char_stream.char_in;
            in_last_reg <= char_stream.last_in;
        end
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign token_stream.valid            = out_valid_reg;
    assign token_stream.char_out         = out_word_reg.char_out;
    assign token_stream.char_valid       = out_word_reg.char_valid;
    assign token_stream.token_end        = out_word_reg.token_end;
    assign token_stream.token_is_command = out_word_reg.token_is_command;
    assign token_stream.token_discard    = out_word_reg.token_discard;
    assign token_stream.line_done        = out_word_reg.line_done;
    assign token_stream.line_valid       = out_word_reg.line_valid;
    assign token_stream.value_count      = out_word_reg.value_count;

    // A waiting input byte is never lost while the result slot is blocked.
    `CLT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    // The line state is back at reset after the last byte of a line is decoded.
    `CLT_ASSERT_NEXT(a_line_clear, clk, rst_n, advance && in_last_reg, state_reg == '0)
    // A token cannot both complete and be discarded on the same byte.
    `CLT_ASSERT_ALWAYS(a_end_xor_discard, clk, rst_n, !(out_valid_reg && out_word_reg.token_end && out_word_reg.token_discard))
    // Once stopped, a line keeps no token open until it is cleared.
    `CLT_ASSERT_ALWAYS(a_stop_closed, clk, rst_n, !(state_reg.line_stopped && state_reg.token_open))

endmodule
